// ----- rtl/core/swaf_pkg.sv -----
// Shared types and constants for the sliding window anagram finder.
package swaf_pkg;

   localparam int unsigned LETTER_BITS = 5;
   localparam int unsigned OPCODE_BITS = 2;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_CLEAR   = 2'd0,
      OP_PATTERN = 2'd1,
      OP_TEXT    = 2'd2
   } opcode_type;

   typedef logic [LETTER_BITS-1:0] letter_type;

   // Balance update for one item: take one from a letter, add one to a letter.
   typedef struct packed {
      logic       clear;
      logic       dec_en;
      letter_type dec_letter;
      logic       inc_en;
      letter_type inc_letter;
   } balance_cmd_type;

endpackage

// ----- rtl/core/swaf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module swaf_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents on a same-address write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/swaf_balance.sv -----
// Per-letter balance lanes and the count of letters whose balance is nonzero.
module swaf_balance #(
   parameter int unsigned PATTERN_MAX   = 64,
   parameter int unsigned ALPHABET_SIZE = 26
) (
   input  logic                      clock,
   input  logic                      reset,
   input  swaf_pkg::balance_cmd_type cmd,
   output logic                      mismatch_zero_next
);

   localparam int unsigned BW = $clog2(PATTERN_MAX + 1) + 1;
   localparam int unsigned MW = $clog2(ALPHABET_SIZE + 1);

   logic signed [BW-1:0] balance_ff [ALPHABET_SIZE];
   logic signed [BW-1:0] balance_in [ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0] inc_hit;
   logic [ALPHABET_SIZE-1:0] dec_hit;
   logic [ALPHABET_SIZE-1:0] went_nz;
   logic [ALPHABET_SIZE-1:0] went_zero;
   logic [MW-1:0] mismatch_ff;
   logic [MW-1:0] mismatch_in;
   logic up_inc, up_dec, dn_inc, dn_dec;

   always_comb begin
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
         inc_hit[i] = cmd.inc_en && (32'(cmd.inc_letter) == 32'(i));
         dec_hit[i] = cmd.dec_en && (32'(cmd.dec_letter) == 32'(i));
         balance_in[i] = balance_ff[i];
         if (inc_hit[i] && !dec_hit[i]) begin
            balance_in[i] = balance_ff[i] + BW'(1);
         end else if (dec_hit[i] && !inc_hit[i]) begin
            balance_in[i] = balance_ff[i] - BW'(1);
         end
         went_nz[i]   = (balance_ff[i] == '0) && (balance_in[i] != '0);
         went_zero[i] = (balance_ff[i] != '0) && (balance_in[i] == '0);
      end
   end

   // At most one lane per role changes, so each reduction acts as a select.
   assign up_inc = |(went_nz & inc_hit);
   assign up_dec = |(went_nz & dec_hit);
   assign dn_inc = |(went_zero & inc_hit);
   assign dn_dec = |(went_zero & dec_hit);

   assign mismatch_in = mismatch_ff + MW'(up_inc) + MW'(up_dec)
                        - MW'(dn_inc) - MW'(dn_dec);

   assign mismatch_zero_next = (mismatch_in == '0);

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         mismatch_ff <= '0;
         for (int i = 0; i < ALPHABET_SIZE; i++) begin
            balance_ff[i] <= '0;
         end
      end else begin
         mismatch_ff <= mismatch_in;
         for (int i = 0; i < ALPHABET_SIZE; i++) begin
            balance_ff[i] <= balance_in[i];
         end
      end
   end

endmodule

// ----- rtl/core/sliding_window_anagram_finder.sv -----
// Top level: input register, search control, text delay line and result register.
//
// Usage: the req channel carries one item per handshake: an opcode (clear,
// pattern letter, text letter) and a letter index. Load the pattern first,
// then stream text. Every text letter that completes a full window of pattern
// length gives one item on the rsp channel: the window's start index, a match
// flag and a sticky flag that the text position has wrapped.
// A text item passes through the input register and then the result register,
// which loads only while the rsp channel is free to take a result.
// One item per cycle while rsp_stall does not hold a waiting result;
// the balance lanes and the nonzero count update in the same cycle, and the
// delay line memory is read one item ahead so the leaving letter is ready.
// Clear, pattern and ignored items give no result.
// While rsp_stall holds a waiting result, the held item in the input register
// waits and req_stall rises; nothing is dropped or repeated.
// Reset returns all balances, counts and the position to zero; no clearing
// pass is needed, delay line entries are only read after being written.
module sliding_window_anagram_finder #(
   parameter int unsigned PATTERN_MAX   = 64,
   parameter int unsigned ALPHABET_SIZE = 26,
   parameter int unsigned INDEX_BITS    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_opcode,
   input  logic [4:0]            req_letter,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [INDEX_BITS-1:0] rsp_start_index,
   output logic                  rsp_match,
   output logic                  rsp_index_overflow
);

   localparam int unsigned AW  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int unsigned PCW = $clog2(PATTERN_MAX + 1);
   localparam int unsigned XW  = ((INDEX_BITS > PCW) ? INDEX_BITS : PCW) + 1;
   localparam int unsigned SW  = $clog2(2 * PATTERN_MAX) + 1;

   // Input register
   logic                     s1_valid_ff, s1_valid_in;
   logic [1:0]               op_ff;
   swaf_pkg::letter_type     letter_ff;

   // Search state
   logic [PCW-1:0]           pc_ff, pc_in;
   logic [INDEX_BITS-1:0]    pos_ff, pos_in;
   logic                     wrapped_ff, wrapped_in;
   logic [AW-1:0]            wptr_ff, wptr_in;
   logic                     byp_ff;
   swaf_pkg::letter_type     byp_data_ff;

   // Result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [INDEX_BITS-1:0]    start_ff;
   logic                     match_ff;
   logic                     overflow_ff;

   logic out_free, s1_ready, proc;
   logic letter_ok, is_clear, pat_ok, txt_ok, started, remove, full;
   logic [XW-1:0] start_wide;
   logic [SW-1:0] rd_sum;
   logic [AW-1:0] rd_addr;
   logic          ram_we;
   swaf_pkg::letter_type ram_rdata, out_letter;
   swaf_pkg::balance_cmd_type bcmd;
   logic match_next;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_ready  = !s1_valid_ff || out_free;
   assign req_stall = !s1_ready;
   assign proc      = s1_valid_ff && out_free;

   assign letter_ok = 32'(letter_ff) < 32'(ALPHABET_SIZE);
   assign started   = wrapped_ff || (pos_ff != '0);
   assign is_clear  = (op_ff == swaf_pkg::OP_CLEAR);
   assign pat_ok    = (op_ff == swaf_pkg::OP_PATTERN) && letter_ok && !started
                      && (32'(pc_ff) < 32'(PATTERN_MAX));
   assign txt_ok    = (op_ff == swaf_pkg::OP_TEXT) && letter_ok && (pc_ff != '0);
   assign remove    = wrapped_ff || (XW'(pos_ff) >= XW'(pc_ff));
   assign full      = wrapped_ff || (XW'(pos_ff) + XW'(1) >= XW'(pc_ff));
   assign start_wide = XW'(pos_ff) + XW'(1) - XW'(pc_ff);

   // Next state
   always_comb begin
      pc_in      = pc_ff;
      pos_in     = pos_ff;
      wrapped_in = wrapped_ff;
      wptr_in    = wptr_ff;
      if (proc && is_clear) begin
         pc_in      = '0;
         pos_in     = '0;
         wrapped_in = 1'b0;
         wptr_in    = '0;
      end else if (proc && pat_ok) begin
         pc_in = pc_ff + PCW'(1);
      end else if (proc && txt_ok) begin
         pos_in     = pos_ff + INDEX_BITS'(1);
         wrapped_in = wrapped_ff || (pos_ff == '1);
         wptr_in    = (32'(wptr_ff) == PATTERN_MAX - 1) ? '0 : wptr_ff + AW'(1);
      end
   end

   // Prefetch the letter that leaves the window on the next text item.
   assign rd_sum  = SW'(wptr_in) + SW'(PATTERN_MAX) - SW'(pc_in);
   assign rd_addr = (rd_sum >= SW'(PATTERN_MAX)) ? AW'(rd_sum - SW'(PATTERN_MAX))
                                                  : AW'(rd_sum);
   assign ram_we  = proc && txt_ok;

   swaf_ram #(
      .WIDTH (swaf_pkg::LETTER_BITS),
      .DEPTH (PATTERN_MAX)
   ) u_recent (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wptr_ff),
      .wr_data (letter_ff),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   assign out_letter = byp_ff ? byp_data_ff : ram_rdata;

   always_comb begin
      bcmd.clear      = proc && is_clear;
      bcmd.dec_en     = proc && (pat_ok || (txt_ok && remove));
      bcmd.dec_letter = pat_ok ? letter_ff : out_letter;
      bcmd.inc_en     = proc && txt_ok;
      bcmd.inc_letter = letter_ff;
   end

   swaf_balance #(
      .PATTERN_MAX   (PATTERN_MAX),
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_balance (
      .clock              (clock),
      .reset              (reset),
      .cmd                (bcmd),
      .mismatch_zero_next (match_next)
   );

   assign s1_valid_in  = s1_ready ? req_valid : s1_valid_ff;
   assign rsp_valid_in = out_free ? (s1_valid_ff && txt_ok && full) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
         pos_ff       <= '0;
         wrapped_ff   <= 1'b0;
         wptr_ff      <= '0;
         byp_ff       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pc_ff        <= pc_in;
         pos_ff       <= pos_in;
         wrapped_ff   <= wrapped_in;
         wptr_ff      <= wptr_in;
         // Read and write hit the same entry: take the written letter.
         byp_ff       <= ram_we && (rd_addr == wptr_ff);
      end
      byp_data_ff <= letter_ff;
      if (req_valid && s1_ready) begin
         op_ff     <= req_opcode;
         letter_ff <= req_letter;
      end
      if (proc && txt_ok && full) begin
         start_ff    <= INDEX_BITS'(start_wide);
         match_ff    <= match_next;
         overflow_ff <= wrapped_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_start_index    = start_ff;
   assign rsp_match          = match_ff;
   assign rsp_index_overflow = overflow_ff;

endmodule
